// ----- rtl/wsmm_pkg.sv -----
// shared types and constants for the windowed sample min/max block
`timescale 1ns / 1ps

package wsmm_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 6;
    localparam int WIN_W    = 7;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 64;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- rtl/windowed_sample_min_max.sv -----
// windowed sample store with min/max report over the filled entries
// the result is registered after a scan over the filled entries
// a new item is accepted only in idle, after the result of the previous one is handed off
// the scan goes through the single read port of the sample memory
// reset: a clearing pass writes zero to all DEPTH entries, one per cycle, ready stays low
// config writes are taken during the clearing pass
`timescale 1ns / 1ps

module windowed_sample_min_max
    import wsmm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [WIN_W-1:0]    i_cfg_wdata,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // sample[15:0], position[21:16], zero[23:22]
    input  logic [IN_W-1:0]     i_s_tdata,
    // action
    input  logic                i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // read_value[15:0], minimum[31:16], maximum[47:32], fill_level[54:48],
    // empty_error[55], position_error[56], zero[63:57]
    output logic [OUT_W-1:0]    o_m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = (AW > WIN_W) ? AW : WIN_W;

    function automatic logic [WIN_W-1:0] f_eff(input logic [WIN_W-1:0] wl);
        logic [WIN_W-1:0] w;
        if (wl == '0) begin
            w = WIN_W'(1);
        end else if (32'(wl) > DEPTH) begin
            w = WIN_W'(DEPTH);
        end else begin
            w = wl;
        end
        return w;
    endfunction

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    t_state r_state, n_state;

    logic [WIN_W-1:0]  r_wl;
    logic [WIN_W-1:0]  r_fill;
    logic [AW-1:0]     r_wr_idx;
    logic [AW-1:0]     r_clr;
    logic [XW-1:0]     r_idx;
    logic [XW-1:0]     r_got;
    logic              r_action;
    logic              r_pos_err;
    logic              r_empty;
    logic signed [SAMPLE_W-1:0] r_read_value;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              mem_we;
    logic [AW-1:0]     mem_wr_addr;
    logic signed [SAMPLE_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;

    logic              in_accept;
    logic              out_load;
    logic [WIN_W-1:0]  w_eff;
    logic [WIN_W-1:0]  w_new;
    logic [POS_W-1:0]  in_pos;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [XW-1:0]     wr_idx_inc;
    logic              scan_last;

    assign w_eff      = f_eff(r_wl);
    assign w_new      = f_eff(i_cfg_wdata);
    assign in_pos     = i_s_tdata[SAMPLE_W+POS_W-1:SAMPLE_W];
    assign in_sample  = i_s_tdata[SAMPLE_W-1:0];
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
    assign wr_idx_inc = XW'(r_wr_idx) + XW'(1);
    assign scan_last  = (r_got == XW'(r_fill) - XW'(1));

    // sample memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        r_rd_data <= r_mem[mem_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = (r_fill == '0) ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_s_tready  = 1'b0;
        mem_we      = 1'b0;
        mem_wr_addr = r_wr_idx;
        mem_wr_data = in_sample;
        mem_rd_addr = r_idx[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_clr;
                mem_wr_data = '0;
            end
            S_IDLE: begin
                o_s_tready  = 1'b1;
                mem_we      = in_accept && (i_s_tuser == ACT_PUSH);
                mem_rd_addr = AW'(in_pos);
            end
            S_FETCH: begin
                mem_rd_addr = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wl        <= WIN_RESET;
            r_fill      <= '0;
            r_wr_idx    <= '0;
            r_idx       <= '0;
            r_got       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                r_wl <= i_cfg_wdata;
                if (r_fill > w_new) begin
                    r_fill <= w_new;
                end
                if (32'(r_wr_idx) >= 32'(w_new)) begin
                    r_wr_idx <= '0;
                end
            end else if (in_accept && (i_s_tuser == ACT_PUSH)) begin
                if (wr_idx_inc >= XW'(w_eff)) begin
                    r_wr_idx <= '0;
                end else begin
                    r_wr_idx <= wr_idx_inc[AW-1:0];
                end
                if (r_fill < w_eff) begin
                    r_fill <= r_fill + WIN_W'(1);
                end
            end
            if (r_state == S_FETCH) begin
                r_idx <= XW'(1);
                r_got <= '0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + XW'(1);
                r_got <= r_got + XW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action  <= i_s_tuser;
            r_pos_err <= (i_s_tuser == ACT_READ) && (WIN_W'(in_pos) >= w_eff);
        end
        if (r_state == S_FETCH) begin
            r_empty <= (r_fill == '0);
            r_min   <= '0;
            r_max   <= '0;
            if ((r_action == ACT_READ) && !r_pos_err) begin
                r_read_value <= r_rd_data;
            end else begin
                r_read_value <= '0;
            end
        end
        if (r_state == S_SCAN) begin
            if (r_got == '0) begin
                r_min <= r_rd_data;
                r_max <= r_rd_data;
            end else begin
                if (r_rd_data < r_min) begin
                    r_min <= r_rd_data;
                end
                if (r_rd_data > r_max) begin
                    r_max <= r_rd_data;
                end
            end
        end
        if (out_load) begin
            r_out_data <= {7'd0, r_pos_err, r_empty, r_fill, r_max, r_min, r_read_value};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_FETCH))
        else $error("accepted item did not start a fetch");

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_fill <= w_eff))
        else $error("fill count beyond window");

    a_wr_idx_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (32'(r_wr_idx) < 32'(w_eff)))
        else $error("write index beyond window");

    a_scan_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_got < XW'(r_fill)))
        else $error("scan ran past fill count");
`endif

endmodule
